// ===== sv/csl_pkg.sv =====
package csl_pkg;

	localparam int KwMaxLen = 8;
	localparam int QDepth   = 4;
	localparam int QAw      = $clog2(QDepth);

	typedef enum logic [2:0] {
		CLS_KEYWORD  = 3'd0,
		CLS_IDENT    = 3'd1,
		CLS_NUMBER   = 3'd2,
		CLS_OPERATOR = 3'd3,
		CLS_ERROR    = 3'd4
	} tok_class_t;

	typedef struct packed {
		tok_class_t  cls;
		logic [31:0] start;
		logic [15:0] length;
		logic        last;
	} tok_rec_t;

	typedef struct packed {
		logic [1:0] n;
		tok_rec_t   r0;
		tok_rec_t   r1;
	} tok_push_t;

endpackage

// ===== sv/csl_core.sv =====
module csl_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          text_byte,
	input  logic                end_of_text,
	input  logic                room,
	output csl_pkg::tok_push_t  push
);

	typedef enum logic [1:0] {MODE_IDLE, MODE_NUM, MODE_IDENT, MODE_OP} mode_t;
	typedef logic [csl_pkg::KwMaxLen-1:0][7:0] win_t;

	localparam int KwIdxW = $clog2(csl_pkg::KwMaxLen);
	localparam int NumKw  = 10;
	localparam logic [63:0] KW_TEXT [NumKw] = '{
		{"while", 24'd0}, {"if", 48'd0}, {"else", 32'd0}, {"return", 16'd0},
		{"break", 24'd0}, "continue", {"int", 40'd0}, {"float", 24'd0},
		{"void", 32'd0}, {"for", 40'd0}
	};
	localparam logic [3:0] KW_LEN [NumKw] = '{
		4'd5, 4'd2, 4'd4, 4'd6, 4'd5, 4'd8, 4'd3, 4'd5, 4'd4, 4'd3
	};

	function automatic logic is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D;
	endfunction

	function automatic win_t win_put(win_t w, logic [15:0] n, logic [7:0] c);
		win_t r;
		r = w;
		if (n < 16'(csl_pkg::KwMaxLen))
			r[n[KwIdxW-1:0]] = c;
		return r;
	endfunction

	function automatic logic [15:0] cnt_inc(logic [15:0] n);
		return (n == 16'hFFFF) ? n : n + 16'd1;
	endfunction

	function automatic logic kw_match(win_t w, logic [15:0] n);
		logic hit;
		logic ok;
		hit = 1'b0;
		for (int k = 0; k < NumKw; k++) begin
			ok = (n == 16'(KW_LEN[k]));
			for (int j = 0; j < 8; j++) begin
				if (j < KW_LEN[k] && w[j] != KW_TEXT[k][8*(7-j) +: 8])
					ok = 1'b0;
			end
			hit = hit | ok;
		end
		return hit;
	endfunction

	function automatic csl_pkg::tok_rec_t fin_rec(mode_t m, logic [15:0] n, win_t w,
			logic [7:0] p, logic [31:0] b);
		csl_pkg::tok_rec_t r;
		r.start  = b;
		r.last   = 1'b0;
		r.cls    = csl_pkg::CLS_ERROR;
		r.length = 16'd1;
		unique case (m)
			MODE_NUM: begin
				r.cls    = csl_pkg::CLS_NUMBER;
				r.length = n;
			end
			MODE_IDENT: begin
				r.cls    = kw_match(w, n) ? csl_pkg::CLS_KEYWORD : csl_pkg::CLS_IDENT;
				r.length = n;
			end
			MODE_OP: begin
				r.cls = (p == "&" || p == "|") ? csl_pkg::CLS_ERROR : csl_pkg::CLS_OPERATOR;
			end
			MODE_IDLE: begin
				r.length = 16'd0;
			end
		endcase
		return r;
	endfunction

	logic        vld_s1;
	logic [7:0]  byte_s1;
	logic        end_s1;
	logic        advance;

	mode_t       mode_q;
	logic        aexp_q;
	logic [31:0] tbeg_q;
	logic [15:0] cnt_q;
	win_t        win_q;
	logic [7:0]  pend_q;
	logic [31:0] pos_q;

	mode_t       md;
	logic        aexp;
	logic [31:0] tb;
	logic [15:0] cnt;
	win_t        win;
	logic [7:0]  pend;
	logic [31:0] pos_n;
	logic        fin1, pairhit, va, vb, vc;
	logic [1:0]  n;
	csl_pkg::tok_rec_t rec_a, rec_b, rec_c, r0, r1;

	assign advance  = vld_s1 & room;
	assign in_stall = vld_s1 & ~room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= text_byte;
			end_s1  <= end_of_text;
		end
	end

	always_comb begin
		md      = mode_q;
		aexp    = aexp_q;
		tb      = tbeg_q;
		cnt     = cnt_q;
		win     = win_q;
		pend    = pend_q;
		fin1    = 1'b0;
		pairhit = 1'b0;
		vb      = 1'b0;
		rec_b.cls    = csl_pkg::CLS_ERROR;
		rec_b.start  = pos_q;
		rec_b.length = 16'd1;
		rec_b.last   = 1'b0;

		unique case (mode_q)
			MODE_NUM: begin
				if (aexp_q) begin
					if (byte_s1 == "-" || is_digit(byte_s1)) begin
						win  = win_put(win, cnt, byte_s1);
						cnt  = cnt_inc(cnt);
						aexp = 1'b0;
					end else begin
						fin1 = 1'b1;
					end
				end else if (is_digit(byte_s1) || byte_s1 == "." || byte_s1 == "E") begin
					win = win_put(win, cnt, byte_s1);
					cnt = cnt_inc(cnt);
					if (byte_s1 == "E")
						aexp = 1'b1;
				end else begin
					fin1 = 1'b1;
				end
			end
			MODE_IDENT: begin
				if (is_alpha(byte_s1) || is_digit(byte_s1) || byte_s1 == "_") begin
					win = win_put(win, cnt, byte_s1);
					cnt = cnt_inc(cnt);
				end else begin
					fin1 = 1'b1;
				end
			end
			MODE_OP: begin
				if ((byte_s1 == "=" && (pend_q == "<" || pend_q == ">" || pend_q == "="
						|| pend_q == "!")) || (byte_s1 == "&" && pend_q == "&")
						|| (byte_s1 == "|" && pend_q == "|"))
					pairhit = 1'b1;
				else
					fin1 = 1'b1;
			end
			MODE_IDLE: begin
			end
		endcase

		va = fin1 | pairhit;
		if (pairhit) begin
			rec_a.cls    = csl_pkg::CLS_OPERATOR;
			rec_a.start  = tbeg_q;
			rec_a.length = 16'd2;
			rec_a.last   = 1'b0;
		end else begin
			rec_a = fin_rec(mode_q, cnt_q, win_q, pend_q, tbeg_q);
		end

		if (va) begin
			md   = MODE_IDLE;
			aexp = 1'b0;
			cnt  = 16'd0;
			pend = 8'd0;
		end

		if ((fin1 || mode_q == MODE_IDLE) && !is_space(byte_s1)) begin
			tb  = pos_q;
			cnt = 16'd0;
			if (is_digit(byte_s1)) begin
				md   = MODE_NUM;
				aexp = 1'b0;
				win  = win_put(win, 16'd0, byte_s1);
				cnt  = 16'd1;
			end else if (is_alpha(byte_s1) || byte_s1 == "_") begin
				md  = MODE_IDENT;
				win = win_put(win, 16'd0, byte_s1);
				cnt = 16'd1;
			end else if (byte_s1 == "<" || byte_s1 == ">" || byte_s1 == "="
					|| byte_s1 == "!" || byte_s1 == "&" || byte_s1 == "|") begin
				md   = MODE_OP;
				pend = byte_s1;
				cnt  = 16'd1;
			end else begin
				vb = 1'b1;
				if (byte_s1 == "(" || byte_s1 == ")" || byte_s1 == "{" || byte_s1 == "}"
						|| byte_s1 == ";" || byte_s1 == "+" || byte_s1 == "-"
						|| byte_s1 == "*" || byte_s1 == "/")
					rec_b.cls = csl_pkg::CLS_OPERATOR;
			end
		end

		rec_c = fin_rec(md, cnt, win, pend, tb);
		vc    = end_s1 && md != MODE_IDLE;

		if (end_s1) begin
			md    = MODE_IDLE;
			aexp  = 1'b0;
			cnt   = 16'd0;
			pend  = 8'd0;
			tb    = 32'd0;
			win   = '0;
			pos_n = 32'd0;
		end else begin
			pos_n = pos_q + 32'd1;
		end

		n = {1'b0, va} + {1'b0, vb} + {1'b0, vc};

		priority if (va) r0 = rec_a;
		else if (vb)     r0 = rec_b;
		else             r0 = rec_c;
		r1 = (va && vb) ? rec_b : rec_c;
		r0.last = (n == 2'd1);
		r1.last = 1'b1;

		push.n  = advance ? n : 2'd0;
		push.r0 = r0;
		push.r1 = r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			aexp_q <= 1'b0;
			tbeg_q <= 32'd0;
			cnt_q  <= 16'd0;
			win_q  <= '0;
			pend_q <= 8'd0;
			pos_q  <= 32'd0;
		end else if (advance) begin
			mode_q <= md;
			aexp_q <= aexp;
			tbeg_q <= tb;
			cnt_q  <= cnt;
			win_q  <= win;
			pend_q <= pend;
			pos_q  <= pos_n;
		end
	end

endmodule

// ===== sv/csl_outq.sv =====
module csl_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  csl_pkg::tok_push_t push,
	output logic               room,
	output logic               out_valid,
	input  logic               out_stall,
	output csl_pkg::tok_rec_t  head
);

	csl_pkg::tok_rec_t       mem_q [csl_pkg::QDepth];
	logic [csl_pkg::QAw-1:0] wp_q;
	logic [csl_pkg::QAw-1:0] rp_q;
	logic [csl_pkg::QAw-1:0] wp_nx;
	logic [csl_pkg::QAw:0]   cnt_q;
	logic                    pop;

	assign out_valid = cnt_q != '0;
	assign pop       = out_valid & ~out_stall;
	assign room      = cnt_q <= (csl_pkg::QAw+1)'(csl_pkg::QDepth - 2);
	assign head      = mem_q[rp_q];
	assign wp_nx     = wp_q + csl_pkg::QAw'(1);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			mem_q[wp_q] <= push.r0;
		if (push.n == 2'd2)
			mem_q[wp_nx] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + csl_pkg::QAw'(push.n);
			if (pop)
				rp_q <= rp_q + csl_pkg::QAw'(1);
			cnt_q <= cnt_q + (csl_pkg::QAw+1)'(push.n) - (csl_pkg::QAw+1)'(pop);
		end
	end

endmodule

// ===== sv/c_subset_lexer.sv =====
// A token record passes from the input stage register through the lexer stage into the output
// queue, and is offered from the queue head.
// Throughput: one byte per cycle; the lexer stage advances whenever the 4-entry output
// queue has room for the up to 2 records of a byte; one record leaves per cycle if not stalled.
// Reset (arst_n low): lexer state, byte position, input stage and output queue clear;
// the next byte is position 0 of a new text.
module c_subset_lexer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_byte,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  token_class,
	output logic [31:0] token_start,
	output logic [15:0] token_length,
	output logic        last_of_run
);

	csl_pkg::tok_push_t push;
	csl_pkg::tok_rec_t  head;
	logic               room;

	csl_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.room        (room),
		.push        (push)
	);

	csl_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign token_class  = head.cls;
	assign token_start  = head.start;
	assign token_length = head.length;
	assign last_of_run  = head.last;

endmodule

// ===== sv/csl_chk.sv =====
module csl_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [7:0]  text_byte,
	input logic        end_of_text,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  token_class,
	input logic [31:0] token_start,
	input logic [15:0] token_length,
	input logic        last_of_run
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(token_class)
			&& $stable(token_start) && $stable(token_length) && $stable(last_of_run))
		else $error("stalled request changed");

	a_err_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_class == csl_pkg::CLS_ERROR |-> token_length == 16'd1)
		else $error("error token length");

	a_op_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_class == csl_pkg::CLS_OPERATOR
			|-> token_length == 16'd1 || token_length == 16'd2)
		else $error("operator token length");

	a_kw_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_class == csl_pkg::CLS_KEYWORD
			|-> token_length >= 16'd2 && token_length <= 16'd8)
		else $error("keyword token length");

	a_rst: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("request offered in reset");

endmodule

bind c_subset_lexer csl_chk u_csl_chk (.*);
